// ===== design/uhtr_pkg.sv =====
// uhtr_pkg: shared types, pid codes and status codes for the usb host
// transaction retry block; no dependencies

package uhtr_pkg;

    // operation codes of a command word
    localparam logic OP_START   = 1'b0;
    localparam logic OP_OUTCOME = 1'b1;

    // usb pid codes
    localparam logic [3:0] PID_NONE  = 4'd0;
    localparam logic [3:0] PID_OUT   = 4'd1;
    localparam logic [3:0] PID_ACK   = 4'd2;
    localparam logic [3:0] PID_DATA0 = 4'd3;
    localparam logic [3:0] PID_IN    = 4'd9;
    localparam logic [3:0] PID_NAK   = 4'd10;
    localparam logic [3:0] PID_DATA1 = 4'd11;
    localparam logic [3:0] PID_SETUP = 4'd13;
    localparam logic [3:0] PID_STALL = 4'd14;

    localparam logic [15:0] NAK_FOREVER = 16'hFFFF;

    // attempts allowed for silent or toggle-mismatch responses (1 to 3)
    localparam logic [1:0] MAX_ATTEMPTS = 2'd3;

    typedef logic [2:0] status_t;

    localparam status_t STATUS_OK          = 3'd0;
    localparam status_t STATUS_STALL       = 3'd1;
    localparam status_t STATUS_NAK_DONE    = 3'd2;
    localparam status_t STATUS_UNEXPECTED  = 3'd3;
    localparam status_t STATUS_NO_COMPLETE = 3'd4;
    localparam status_t STATUS_RETRY_DONE  = 3'd5;
    localparam status_t STATUS_BAD_TOKEN   = 3'd6;

    typedef struct packed {
        logic        operation;
        logic [3:0]  start_pid;
        logic [3:0]  endpoint;
        logic        toggle;
        logic [15:0] nak_budget;
        logic        completed;
        logic        toggle_ok;
        logic [3:0]  response_pid;
    } cmd_t;

    typedef struct packed {
        logic        finished;
        logic [3:0]  issue_pid;
        logic [3:0]  issue_endpoint;
        logic        issue_toggle;
        status_t     status;
        logic [3:0]  last_response;
    } rsp_t;

    // status seen by the top level for checking
    typedef struct packed {
        logic busy;
        logic fire;
        logic res_valid;
        logic res_finished;
    } ctl_t;

endpackage

// ===== design/uhtr_cmd_if.sv =====
// uhtr_cmd_if: valid/ready channel carrying one command word
// depends on nothing

interface uhtr_cmd_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [3:0]  start_pid;
    logic [3:0]  endpoint;
    logic        toggle;
    logic [15:0] nak_budget;
    logic        completed;
    logic        toggle_ok;
    logic [3:0]  response_pid;

    modport source (
        output valid, operation, start_pid, endpoint, toggle, nak_budget,
               completed, toggle_ok, response_pid,
        input  ready
    );

    modport sink (
        input  valid, operation, start_pid, endpoint, toggle, nak_budget,
               completed, toggle_ok, response_pid,
        output ready
    );
endinterface

// ===== design/uhtr_rsp_if.sv =====
// uhtr_rsp_if: valid/ready channel carrying one result word
// depends on nothing

interface uhtr_rsp_if;
    logic        valid;
    logic        ready;
    logic        finished;
    logic [3:0]  issue_pid;
    logic [3:0]  issue_endpoint;
    logic        issue_toggle;
    logic [2:0]  status;
    logic [3:0]  last_response;

    modport source (
        output valid, finished, issue_pid, issue_endpoint, issue_toggle,
               status, last_response,
        input  ready
    );

    modport sink (
        input  valid, finished, issue_pid, issue_endpoint, issue_toggle,
               status, last_response,
        output ready
    );
endinterface

// ===== design/uhtr_in_stage.sv =====
// uhtr_in_stage: input register for command words
// depends on uhtr_pkg and uhtr_cmd_if

module uhtr_in_stage
    import uhtr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    uhtr_cmd_if.sink  cmd,
    input  logic      advance,
    output logic      item_valid,
    output cmd_t      item
);

    logic valid_reg;
    logic valid_next;
    cmd_t item_reg;

    assign cmd.ready  = !valid_reg || advance;
    assign valid_next = (cmd.valid && cmd.ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg.operation    <= cmd.operation;
            item_reg.start_pid    <= cmd.start_pid;
            item_reg.endpoint     <= cmd.endpoint;
            item_reg.toggle       <= cmd.toggle;
            item_reg.nak_budget   <= cmd.nak_budget;
            item_reg.completed    <= cmd.completed;
            item_reg.toggle_ok    <= cmd.toggle_ok;
            item_reg.response_pid <= cmd.response_pid;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/uhtr_decide.sv =====
// uhtr_decide: transaction state and per-word decision logic
// depends on uhtr_pkg

module uhtr_decide
    import uhtr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  cmd_t item,
    output logic res_valid,
    output rsp_t res,
    output logic busy
);

    logic        busy_reg, busy_next;
    logic [3:0]  token_reg, token_next;
    logic [3:0]  endpoint_reg, endpoint_next;
    logic        toggle_reg, toggle_next;
    logic [15:0] nak_left_reg, nak_left_next;
    logic [1:0]  attempts_reg, attempts_next;

    always_comb
    begin
        logic        do_issue;
        logic        do_done;
        logic        do_retry;
        status_t     st;
        logic [3:0]  resp;
        logic [3:0]  want;
        logic [1:0]  att_inc;

        busy_next     = busy_reg;
        token_next    = token_reg;
        endpoint_next = endpoint_reg;
        toggle_next   = toggle_reg;
        nak_left_next = nak_left_reg;
        attempts_next = attempts_reg;
        do_issue      = 1'b0;
        do_done       = 1'b0;
        do_retry      = 1'b0;
        st            = STATUS_OK;
        resp          = item.response_pid;
        want          = toggle_reg ? PID_DATA1 : PID_DATA0;
        att_inc       = attempts_reg + 2'd1;

        if (item.operation == OP_START)
        begin
            token_next    = item.start_pid;
            endpoint_next = item.endpoint;
            toggle_next   = item.toggle;
            nak_left_next = item.nak_budget;
            attempts_next = 2'd0;
            busy_next     = 1'b1;
            do_issue      = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!item.completed)
            begin
                do_done = 1'b1;
                st      = STATUS_NO_COMPLETE;
                resp    = PID_NONE;
            end
            else if (item.toggle_ok)
            begin
                do_done = 1'b1;
                st      = STATUS_OK;
            end
            else if (item.response_pid == PID_STALL)
            begin
                do_done = 1'b1;
                st      = STATUS_STALL;
            end
            else if (item.response_pid == PID_NAK)
            begin
                if (nak_left_reg == 16'd0)
                begin
                    do_done = 1'b1;
                    st      = STATUS_NAK_DONE;
                end
                else
                begin
                    if (nak_left_reg != NAK_FOREVER)
                    begin
                        nak_left_next = nak_left_reg - 16'd1;
                    end
                    do_issue = 1'b1;
                end
            end
            else if (token_reg == PID_SETUP || token_reg == PID_OUT)
            begin
                if (item.response_pid == PID_ACK)
                begin
                    do_done = 1'b1;
                    st      = STATUS_OK;
                end
                else if (item.response_pid != PID_NONE)
                begin
                    do_done = 1'b1;
                    st      = STATUS_UNEXPECTED;
                end
                else
                begin
                    do_retry = 1'b1;
                end
            end
            else if (token_reg == PID_IN)
            begin
                if (item.response_pid == want)
                begin
                    do_done = 1'b1;
                    st      = STATUS_OK;
                end
                else if (item.response_pid == PID_DATA0 || item.response_pid == PID_DATA1
                         || item.response_pid == PID_NONE)
                begin
                    do_retry = 1'b1;
                end
                else
                begin
                    do_done = 1'b1;
                    st      = STATUS_UNEXPECTED;
                end
            end
            else
            begin
                do_done = 1'b1;
                st      = STATUS_BAD_TOKEN;
            end

            // silent or wrong-toggle response costs one attempt
            if (do_retry)
            begin
                attempts_next = att_inc;
                if (att_inc >= MAX_ATTEMPTS)
                begin
                    do_done = 1'b1;
                    st      = STATUS_RETRY_DONE;
                end
                else
                begin
                    do_issue = 1'b1;
                end
            end
        end

        if (do_done)
        begin
            busy_next = 1'b0;
        end

        res_valid = do_issue || do_done;
        if (do_done)
        begin
            res.finished       = 1'b1;
            res.issue_pid      = 4'd0;
            res.issue_endpoint = 4'd0;
            res.issue_toggle   = 1'b0;
            res.status         = st;
            res.last_response  = resp;
        end
        else
        begin
            res.finished       = 1'b0;
            res.issue_pid      = token_next;
            res.issue_endpoint = endpoint_next;
            res.issue_toggle   = toggle_next;
            res.status         = STATUS_OK;
            res.last_response  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            token_reg    <= 4'd0;
            endpoint_reg <= 4'd0;
            toggle_reg   <= 1'b0;
            nak_left_reg <= 16'd0;
            attempts_reg <= 2'd0;
        end
        else if (fire)
        begin
            busy_reg     <= busy_next;
            token_reg    <= token_next;
            endpoint_reg <= endpoint_next;
            toggle_reg   <= toggle_next;
            nak_left_reg <= nak_left_next;
            attempts_reg <= attempts_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== design/uhtr_out_fifo.sv =====
// uhtr_out_fifo: two-word result buffer driving the response channel
// depends on uhtr_pkg and uhtr_rsp_if

module uhtr_out_fifo
    import uhtr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rsp_t      push_data,
    output logic      full,
    output logic [1:0] count,
    uhtr_rsp_if.source rsp
);

    rsp_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    rsp_t       head;

    assign pop         = rsp.valid && rsp.ready;
    assign wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head = mem[rd_ptr_reg];

    assign full               = (count_reg == 2'd2);
    assign count              = count_reg;
    assign rsp.valid          = (count_reg != 2'd0);
    assign rsp.finished       = head.finished;
    assign rsp.issue_pid      = head.issue_pid;
    assign rsp.issue_endpoint = head.issue_endpoint;
    assign rsp.issue_toggle   = head.issue_toggle;
    assign rsp.status         = head.status;
    assign rsp.last_response  = head.last_response;

endmodule

// ===== design/usb_host_transaction_retry.sv =====
// usb_host_transaction_retry: top level of the host transaction retry block
// depends on uhtr_pkg, uhtr_cmd_if, uhtr_rsp_if, uhtr_in_stage, uhtr_decide,
// uhtr_out_fifo

// Host-side usb transaction handler. A start word latches token pid,
// endpoint, data toggle and a nak budget (all ones is unlimited) and answers
// with an issue-token word. Each outcome word is decided against the stored
// transaction: the block either finishes with a status (ok, stall, nak budget
// exhausted, unexpected response, no completion, retries exhausted, bad
// token) or issues the same token again. A nak spends budget; a silent
// response or a wrong data toggle on an in token spends one of three
// attempts. An outcome word while idle gives no result; a start word while
// busy abandons the running transaction. One word is taken every clock while
// the result buffer is not full: the word lands in an input register, and
// the decision logic runs it against the stored transaction and writes a
// two-word result buffer that drives rsp. The buffer keeps cmd moving while
// a result waits; cmd stalls only when both buffer entries are occupied and
// the input register holds a word.

module usb_host_transaction_retry
    import uhtr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    uhtr_cmd_if.sink   cmd,
    uhtr_rsp_if.source rsp
);

    logic       item_valid;
    cmd_t       item;
    logic       advance;
    logic       fifo_full;
    logic [1:0] fifo_count;
    logic       res_valid;
    rsp_t       res;
    logic       busy;
    ctl_t       ctl;

    // decision runs whenever a word is held and the buffer has room for a possible result
    assign advance = item_valid && !fifo_full;

    uhtr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    uhtr_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res),
        .busy      (busy)
    );

    uhtr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && res_valid),
        .push_data (res),
        .full      (fifo_full),
        .count     (fifo_count),
        .rsp       (rsp)
    );

    // grouped control view for the checks below
    assign ctl.busy         = busy;
    assign ctl.fire         = advance;
    assign ctl.res_valid    = res_valid;
    assign ctl.res_finished = res.finished;

    // a start word always leaves a transaction running
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && item.operation == OP_START |=> ctl.busy)
        else $error("start word did not open a transaction");

    // a finishing result always closes the transaction
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && ctl.res_valid && ctl.res_finished |=> !ctl.busy)
        else $error("finished result left transaction busy");

    // the result buffer never overfills
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count != 2'd3)
        else $error("result buffer overflow");

    // an outcome while idle never produces a result
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && !ctl.busy && item.operation == OP_OUTCOME |-> !ctl.res_valid)
        else $error("result produced for outcome while idle");

endmodule
